### rtl/qfc_pkg.sv
package qfc_pkg;

  localparam int unsigned FlowEntriesDefault = 64;
  localparam int unsigned QueueDepth         = 2;

  localparam logic [15:0] EthIpv4   = 16'h0800;
  localparam logic [15:0] EthIpv6   = 16'h86DD;
  localparam logic [7:0]  ProtoUdp  = 8'd17;
  localparam logic [16:0] MinFrame  = 17'd43;
  localparam logic [16:0] MinFrame6 = 17'd63;
  localparam logic [7:0]  FormMask  = 8'hC0;
  localparam logic [7:0]  FixedBit  = 8'h40;
  localparam logic [3:0]  IhlMask   = 4'hF;
  localparam logic [31:0] QuicV1    = 32'h00000001;
  localparam logic [31:0] QuicV2    = 32'h6b3343cf;
  localparam logic [31:0] DraftMask = 32'hff000000;

  // Frame kind handed from parser to flow table
  localparam logic [1:0] KindNone  = 2'd0;
  localparam logic [1:0] KindLong  = 2'd1;
  localparam logic [1:0] KindShort = 2'd2;

  // Result status
  localparam logic [1:0] StNone    = 2'd0;
  localparam logic [1:0] StUpdated = 2'd1;
  localparam logic [1:0] StNew     = 2'd2;
  localparam logic [1:0] StFull    = 2'd3;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] version;
    logic [31:0] ip_src;
    logic [31:0] ip_dst;
    logic [31:0] ports;
    logic [15:0] frame_len;
    logic [63:0] now_ns;
  } desc_t;

  typedef struct packed {
    logic [63:0] packets;
    logic [63:0] bytes;
    logic [5:0]  flow_index;
    logic [31:0] seen_version;
    logic        is_long;
    logic [1:0]  status;
  } result_t;

endpackage

### rtl/quic_flow_classifier.sv
// QUIC flow classifier.
// Slave stream: one Ethernet frame byte per transaction, from the destination
// address on; tlast marks the final byte, and tdata also carries the current
// time, sampled on that final byte. A byte is taken whenever the queue is not full.
// Master stream: one result transaction per frame, with the status (not
// counted, flow updated, new flow, table full), the QUIC header form and
// version, the flow slot and the flow's byte and packet totals.
// The parser classifies the frame as bytes arrive and hands a summary to a
// two-entry queue. The flow table behind it walks the used slots (at most
// FLOW_ENTRIES) one per cycle through a registered memory read. Slots fill
// from the bottom and never free, so a fill count replaces per-slot valid
// bits.
// Reset empties the table and the queue at once; no clearing pass is needed.
// While the master side stalls, the result holds in the output register, the
// table finishes at most one more frame, and the parser keeps taking bytes
// until the queue is full, then drops tready.
module quic_flow_classifier #(
  parameter int unsigned FLOW_ENTRIES = qfc_pkg::FlowEntriesDefault
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid_i,
  output logic          s_axis_tready_o,
  input  logic [71:0]   s_axis_tdata_i,   // data_byte[7:0], now_ns[71:8]
  input  logic          s_axis_tlast_i,   // frame_end
  output logic          m_axis_tvalid_o,
  input  logic          m_axis_tready_i,
  // status[1:0], is_long[2], seen_version[34:3], flow_index[40:35],
  // total_bytes[104:41], total_packets[168:105], zero fill[175:169]
  output logic [175:0]  m_axis_tdata_o
);

  logic             q_full, q_empty, q_pop, push, byte_acc;
  qfc_pkg::desc_t   desc_in, desc_out;
  qfc_pkg::result_t res;

  assign s_axis_tready_o = !q_full;
  assign byte_acc        = s_axis_tvalid_i && !q_full;

  qfc_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_valid_i (byte_acc),
    .data_byte_i  (s_axis_tdata_i[7:0]),
    .frame_end_i  (s_axis_tlast_i),
    .now_ns_i     (s_axis_tdata_i[71:8]),
    .push_o       (push),
    .desc_o       (desc_in)
  );

  qfc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .desc_i  (desc_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .desc_o  (desc_out)
  );

  qfc_flow_table #(
    .FLOW_ENTRIES (FLOW_ENTRIES)
  ) u_flow_table (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (q_empty),
    .desc_i      (desc_out),
    .pop_o       (q_pop),
    .res_valid_o (m_axis_tvalid_o),
    .res_o       (res),
    .res_ready_i (m_axis_tready_i)
  );

  assign m_axis_tdata_o = {7'd0, res};

endmodule

### rtl/qfc_parser.sv
module qfc_parser (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           byte_valid_i,
  input  logic [7:0]     data_byte_i,
  input  logic           frame_end_i,
  input  logic [63:0]    now_ns_i,
  output logic           push_o,
  output qfc_pkg::desc_t desc_o
);

  logic [15:0] pos_q, pos_d;
  logic [15:0] etype_q, etype_d;
  logic [3:0]  ihl_q, ihl_d;
  logic [7:0]  proto_q, proto_d;
  logic [31:0] src_q, src_d;
  logic [31:0] dst_q, dst_d;
  logic [15:0] sport_q, sport_d;
  logic [15:0] dport_q, dport_d;
  logic [15:0] ulen_q, ulen_d;
  logic [7:0]  qfirst_q, qfirst_d;
  logic [31:0] ver_q, ver_d;
  logic [16:0] len;
  logic [16:0] uo;
  logic [15:0] udp_rel;
  logic        is_v4, is_v6;
  logic [1:0]  kind;
  logic [31:0] ver_ok;

  assign len   = (pos_q == 16'hFFFF) ? 17'd65535 : {1'b0, pos_q} + 17'd1;
  assign is_v4 = (etype_q == qfc_pkg::EthIpv4);
  assign is_v6 = (etype_q == qfc_pkg::EthIpv6);

  always_comb begin
    etype_d  = etype_q;
    ihl_d    = ihl_q;
    proto_d  = proto_q;
    src_d    = src_q;
    dst_d    = dst_q;
    sport_d  = sport_q;
    dport_d  = dport_q;
    ulen_d   = ulen_q;
    qfirst_d = qfirst_q;
    ver_d    = ver_q;
    uo       = '0;
    udp_rel  = '0;
    if (pos_q == 16'd12) begin
      etype_d = {data_byte_i, etype_q[7:0]};
    end else if (pos_q == 16'd13) begin
      etype_d = {etype_q[15:8], data_byte_i};
    end else if (pos_q >= 16'd14 && (is_v4 || is_v6)) begin
      if (is_v4) begin
        if (pos_q == 16'd14) ihl_d = data_byte_i[3:0] & qfc_pkg::IhlMask;
        if (pos_q == 16'd23) proto_d = data_byte_i;
        if (pos_q >= 16'd26 && pos_q <= 16'd29) src_d = {src_q[23:0], data_byte_i};
        if (pos_q >= 16'd30 && pos_q <= 16'd33) dst_d = {dst_q[23:0], data_byte_i};
        uo = 17'd14 + {11'd0, ihl_d, 2'b00};
      end else begin
        if (pos_q == 16'd20) proto_d = data_byte_i;
        if (pos_q >= 16'd22 && pos_q <= 16'd25) src_d = {src_q[23:0], data_byte_i};
        if (pos_q >= 16'd38 && pos_q <= 16'd41) dst_d = {dst_q[23:0], data_byte_i};
        uo = 17'd54;
      end
      if ({1'b0, pos_q} >= uo) begin
        udp_rel = pos_q - uo[15:0];
        if (udp_rel <= 16'd1) sport_d = {sport_q[7:0], data_byte_i};
        else if (udp_rel <= 16'd3) dport_d = {dport_q[7:0], data_byte_i};
        else if (udp_rel <= 16'd5) ulen_d = {ulen_q[7:0], data_byte_i};
        else if (udp_rel == 16'd8) qfirst_d = data_byte_i;
        else if (udp_rel >= 16'd9 && udp_rel <= 16'd12) ver_d = {ver_q[23:0], data_byte_i};
      end
    end
  end

  // Classify on the final byte using this byte's captures
  always_comb begin
    kind = qfc_pkg::KindNone;
    if (len >= qfc_pkg::MinFrame && proto_d == qfc_pkg::ProtoUdp &&
        ((is_v4 && ihl_d >= 4'd5) || (is_v6 && len >= qfc_pkg::MinFrame6)) &&
        len >= uo + 17'd9 && ulen_d >= 16'd9 && (qfirst_d & qfc_pkg::FixedBit) != 8'd0) begin
      if ((qfirst_d & qfc_pkg::FormMask) == qfc_pkg::FormMask) begin
        kind = (len < uo + 17'd13) ? qfc_pkg::KindNone : qfc_pkg::KindLong;
      end else begin
        kind = qfc_pkg::KindShort;
      end
    end
    if (kind == qfc_pkg::KindLong &&
        (ver_d == qfc_pkg::QuicV1 || ver_d == qfc_pkg::QuicV2 ||
         (ver_d & qfc_pkg::DraftMask) == qfc_pkg::DraftMask)) begin
      ver_ok = ver_d;
    end else begin
      ver_ok = '0;
    end
  end

  assign pos_d  = len[15:0];
  assign push_o = byte_valid_i && frame_end_i;

  always_comb begin
    desc_o.kind      = kind;
    desc_o.version   = ver_ok;
    desc_o.ip_src    = src_d;
    desc_o.ip_dst    = dst_d;
    desc_o.ports     = {sport_d, dport_d};
    desc_o.frame_len = len[15:0];
    desc_o.now_ns    = now_ns_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0; etype_q <= '0; ihl_q <= '0; proto_q <= '0;
      src_q <= '0; dst_q <= '0; sport_q <= '0; dport_q <= '0;
      ulen_q <= '0; qfirst_q <= '0; ver_q <= '0;
    end else if (byte_valid_i) begin
      if (frame_end_i) begin
        // drop per-frame state
        pos_q <= '0; etype_q <= '0; ihl_q <= '0; proto_q <= '0;
        src_q <= '0; dst_q <= '0; sport_q <= '0; dport_q <= '0;
        ulen_q <= '0; qfirst_q <= '0; ver_q <= '0;
      end else begin
        pos_q <= pos_d; etype_q <= etype_d; ihl_q <= ihl_d; proto_q <= proto_d;
        src_q <= src_d; dst_q <= dst_d; sport_q <= sport_d; dport_q <= dport_d;
        ulen_q <= ulen_d; qfirst_q <= qfirst_d; ver_q <= ver_d;
      end
    end
  end

endmodule

### rtl/qfc_queue.sv
module qfc_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  qfc_pkg::desc_t desc_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output qfc_pkg::desc_t desc_o
);

  localparam int unsigned PtrW = $clog2(qfc_pkg::QueueDepth);
  localparam int unsigned CntW = $clog2(qfc_pkg::QueueDepth + 1);

  qfc_pkg::desc_t slot_q [qfc_pkg::QueueDepth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;

  assign full_o  = (cnt_q == CntW'(qfc_pkg::QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign desc_o  = slot_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wr_q] <= desc_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PtrW'(qfc_pkg::QueueDepth - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == PtrW'(qfc_pkg::QueueDepth - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push_i && !pop_i) cnt_q <= cnt_q + 1'b1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule

### rtl/qfc_flow_table.sv
module qfc_flow_table #(
  parameter int unsigned FLOW_ENTRIES = qfc_pkg::FlowEntriesDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             empty_i,
  input  qfc_pkg::desc_t   desc_i,
  output logic             pop_o,
  output logic             res_valid_o,
  output qfc_pkg::result_t res_o,
  input  logic             res_ready_i
);

  localparam int unsigned IdxW = (FLOW_ENTRIES > 1) ? $clog2(FLOW_ENTRIES) : 1;
  localparam int unsigned CntW = $clog2(FLOW_ENTRIES + 1);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StScan = 2'd1;
  localparam logic [1:0] StDone = 2'd2;

  logic [1:0]  state_q, state_d;
  logic [CntW-1:0] fill_q, fill_d;
  logic [CntW-1:0] issue_q, issue_d;
  logic        cmp_v_q, cmp_v_d;
  logic [IdxW-1:0] cmp_idx_q, cmp_idx_d;
  logic [IdxW-1:0] rd_addr;

  qfc_pkg::desc_t   cur_q, cur_d;
  qfc_pkg::result_t res_q, res_d;
  logic [IdxW-1:0]  slot_q, slot_d;
  logic             out_v_q, out_v_d;
  qfc_pkg::result_t out_q, out_d;
  logic             out_free;
  logic             finish;

  logic [95:0]  tup_mem [FLOW_ENTRIES];
  logic [127:0] ctr_mem [FLOW_ENTRIES];
  logic [63:0]  seen_mem [FLOW_ENTRIES];
  logic [31:0]  ver_mem [FLOW_ENTRIES];
  logic         long_mem [FLOW_ENTRIES];
  logic [95:0]  tup_rd_q;
  logic [127:0] ctr_rd_q;
  logic [95:0]  key;
  logic [63:0]  len64;

  assign key      = {cur_q.ip_src, cur_q.ip_dst, cur_q.ports};
  assign len64    = {48'd0, cur_q.frame_len};
  assign out_free = !out_v_q || res_ready_i;
  assign rd_addr  = issue_q[IdxW-1:0];
  assign finish   = (state_q == StDone) && out_free;
  assign pop_o    = (state_q == StIdle) && !empty_i;

  always_comb begin
    state_d   = state_q;
    fill_d    = fill_q;
    issue_d   = issue_q;
    cmp_v_d   = 1'b0;
    cmp_idx_d = cmp_idx_q;
    cur_d     = cur_q;
    res_d     = res_q;
    slot_d    = slot_q;
    out_v_d   = out_v_q && !res_ready_i;
    out_d     = out_q;
    unique case (state_q)
      StIdle: begin
        if (!empty_i) begin
          cur_d   = desc_i;
          issue_d = '0;
          res_d   = '0;
          if (desc_i.kind == qfc_pkg::KindNone) begin
            res_d.status = qfc_pkg::StNone;
            state_d      = StDone;
          end else begin
            state_d = StScan;
          end
        end
      end
      StScan: begin
        res_d.is_long      = (cur_q.kind == qfc_pkg::KindLong);
        res_d.seen_version = cur_q.version;
        if (cmp_v_q && tup_rd_q == key) begin
          // hit: totals from the entry just read
          res_d.status     = qfc_pkg::StUpdated;
          res_d.flow_index = 6'(cmp_idx_q);
          res_d.bytes      = ctr_rd_q[127:64] + len64;
          res_d.packets    = ctr_rd_q[63:0] + 64'd1;
          slot_d           = cmp_idx_q;
          state_d          = StDone;
        end else if (issue_q < fill_q) begin
          cmp_v_d   = 1'b1;
          cmp_idx_d = rd_addr;
          issue_d   = issue_q + 1'b1;
        end else if (fill_q < CntW'(FLOW_ENTRIES)) begin
          res_d.status     = qfc_pkg::StNew;
          res_d.flow_index = 6'(fill_q[IdxW-1:0]);
          res_d.bytes      = len64;
          res_d.packets    = 64'd1;
          slot_d           = fill_q[IdxW-1:0];
          state_d          = StDone;
        end else begin
          res_d.status = qfc_pkg::StFull;
          state_d      = StDone;
        end
      end
      StDone: begin
        if (out_free) begin
          out_v_d = 1'b1;
          out_d   = res_q;
          if (res_q.status == qfc_pkg::StNew) fill_d = fill_q + 1'b1;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // Table storage: one read address per cycle, writes on completion
  always_ff @(posedge clk_i) begin
    tup_rd_q <= tup_mem[rd_addr];
    ctr_rd_q <= ctr_mem[rd_addr];
    if (finish && (res_q.status == qfc_pkg::StNew ||
                   res_q.status == qfc_pkg::StUpdated)) begin
      ctr_mem[slot_q]  <= {res_q.bytes, res_q.packets};
      seen_mem[slot_q] <= cur_q.now_ns;
      long_mem[slot_q] <= res_q.is_long;
      if (res_q.status == qfc_pkg::StNew) tup_mem[slot_q] <= key;
      if (res_q.status == qfc_pkg::StNew || cur_q.version != '0) begin
        ver_mem[slot_q] <= cur_q.version;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q     <= cur_d;
    res_q     <= res_d;
    slot_q    <= slot_d;
    out_q     <= out_d;
    cmp_idx_q <= cmp_idx_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      fill_q  <= '0;
      issue_q <= '0;
      cmp_v_q <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      issue_q <= issue_d;
      cmp_v_q <= cmp_v_d;
      out_v_q <= out_v_d;
    end
  end

  assign res_valid_o = out_v_q;
  assign res_o       = out_q;

endmodule
